>>> src/stidl_pkg.sv
// stidl_pkg: shared types and constants of the slot table with id lookup
// holds the word structs, mode codes and the token that walks the cell row
// no dependencies
`default_nettype none

package stidl_pkg;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 3;
    localparam int KEY_W    = 10;
    localparam int SID_W    = 16;
    localparam int OUT_ID_W = 16;
    localparam int SLOT_RANGE = 2 ** SLOT_W;

    localparam logic [KEY_W-1:0] KEY_LIMIT_RESET = KEY_W'(1000);
    localparam logic [KEY_W-1:0] MIN_INSERT_KEY  = KEY_W'(1);

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BYID   = 3'd4;

    // register indexes of the configuration port
    localparam logic REG_KEY_LIMIT = 1'b0;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key_in;
        logic [SID_W-1:0]  search_id;
    } t_in_word;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] found_slot;
        logic [OUT_ID_W-1:0] assigned_id;
    } t_out_word;

    // command token handed from cell to cell
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [SID_W-1:0]  sid;
        logic              done;
        logic              err;
        logic [SLOT_W-1:0] hit_slot;
    } t_tok;

endpackage

`default_nettype wire

>>> src/stidl_cell.sv
// stidl_cell: one slot of the table, holding valid bit, key and id
// acts on the token passing by and hands it on through its own register; uses stidl_pkg
`default_nettype none

module stidl_cell #(
    parameter int IDX     = 0,
    parameter int ID_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_adv,
    input  wire                     i_vld,
    input  stidl_pkg::t_tok         i_tok,
    input  wire [ID_BITS-1:0]       i_new_id,
    input  wire [ID_BITS-1:0]       i_res_id,
    output logic                    o_vld,
    output stidl_pkg::t_tok         o_tok,
    output logic [ID_BITS-1:0]      o_new_id,
    output logic [ID_BITS-1:0]      o_res_id
);

    localparam int CMP_W = (ID_BITS > stidl_pkg::SID_W) ? ID_BITS : stidl_pkg::SID_W;
    localparam logic [stidl_pkg::SLOT_W-1:0] MY_SLOT = stidl_pkg::SLOT_W'(IDX);
    localparam bit ADDRESSABLE = (IDX < stidl_pkg::SLOT_RANGE);

    logic                          r_valid;
    logic [stidl_pkg::KEY_W-1:0]   r_key;
    logic [ID_BITS-1:0]            r_id;
    logic                          r_vld;
    stidl_pkg::t_tok               r_tok;
    logic [ID_BITS-1:0]            r_new_id;
    logic [ID_BITS-1:0]            r_res_id;

    logic                          n_valid;
    logic [stidl_pkg::KEY_W-1:0]   n_key;
    logic [ID_BITS-1:0]            n_id;
    stidl_pkg::t_tok               n_tok;
    logic [ID_BITS-1:0]            n_res_id;
    logic                          w_here;
    logic                          w_id_eq;

    assign w_here  = ADDRESSABLE && (i_tok.slot == MY_SLOT);
    assign w_id_eq = (CMP_W'(r_id) == CMP_W'(i_tok.sid));

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_id     = r_id;
        n_tok    = i_tok;
        n_res_id = i_res_id;
        if (i_vld && !i_tok.done) begin
            case (i_tok.mode)
                stidl_pkg::MODE_INSERT: begin
                    if (w_here) begin
                        n_tok.done = 1'b1;
                        if (r_valid) begin
                            n_tok.err = 1'b1;
                        end else begin
                            n_valid  = 1'b1;
                            n_key    = i_tok.key;
                            n_id     = i_new_id;
                            n_res_id = i_new_id;
                        end
                    end
                end
                stidl_pkg::MODE_MODIFY: begin
                    if (w_here) begin
                        n_tok.done = 1'b1;
                        if (!r_valid) begin
                            n_tok.err = 1'b1;
                        end else begin
                            n_key    = i_tok.key;
                            n_res_id = r_id;
                        end
                    end
                end
                stidl_pkg::MODE_REMOVE: begin
                    if (w_here) begin
                        n_tok.done = 1'b1;
                        if (!r_valid) begin
                            n_tok.err = 1'b1;
                        end else begin
                            n_valid  = 1'b0;
                            n_res_id = r_id;
                        end
                    end
                end
                stidl_pkg::MODE_FREE: begin
                    if (!r_valid) begin
                        n_tok.done     = 1'b1;
                        n_tok.hit_slot = MY_SLOT;
                    end
                end
                stidl_pkg::MODE_BYID: begin
                    if (r_valid && w_id_eq) begin
                        n_tok.done     = 1'b1;
                        n_tok.hit_slot = MY_SLOT;
                        n_res_id       = r_id;
                    end
                end
                default: begin
                    // bad modes are flagged before the row
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_vld   <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key    <= n_key;
            r_id     <= n_id;
            r_tok    <= n_tok;
            r_new_id <= i_new_id;
            r_res_id <= n_res_id;
        end
    end

    assign o_vld    = r_vld;
    assign o_tok    = r_tok;
    assign o_new_id = r_new_id;
    assign o_res_id = r_res_id;

endmodule

`default_nettype wire

>>> src/slot_table_with_id_lookup.sv
// slot_table_with_id_lookup: top level of the slot table with id allocator
// holds the APB register, id counter, command entry and result register; uses
// stidl_pkg and a row of stidl_cell
`default_nettype none

// A table of ENTRIES slots, each held in one cell of a row. An accepted command
// word is checked for key range and mode, then walks the row one cell per cycle
// while the row is not frozen; the cell of the addressed slot (or the first cell
// that matches a search) resolves it. The result word passes the entry register,
// one register per cell and the result register. One command is in flight at a
// time and the input opens again as the result is loaded, so a new command is
// taken only once the last one has walked through the cell row. A finished result
// may wait in the output register while the next command is taken in; the row
// freezes only when the next result reaches its end while the old one still waits.
module slot_table_with_id_lookup #(
    parameter int ENTRIES = 8,
    parameter int ID_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  stidl_pkg::t_in_word   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output stidl_pkg::t_out_word  o_out_data,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [2:0]             paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CMP_W = (ID_BITS > stidl_pkg::OUT_ID_W) ? ID_BITS : stidl_pkg::OUT_ID_W;

    logic [stidl_pkg::KEY_W-1:0] r_key_limit;
    logic [ID_BITS-1:0]          r_cnt;
    logic                        r_busy;
    logic                        r_vld0;
    stidl_pkg::t_tok             r_tok0;
    logic [ID_BITS-1:0]          r_new0;
    logic                        r_out_vld;
    stidl_pkg::t_out_word        r_out;

    stidl_pkg::t_tok             n_tok0;
    stidl_pkg::t_out_word        n_out;
    logic                        w_pre_err;
    logic                        w_accept;
    logic                        w_adv;
    logic                        w_last;
    logic                        w_ok;
    logic                        w_reg_wr;
    logic [CMP_W-1:0]            w_res_ext;

    logic                        w_vld    [ENTRIES+1];
    stidl_pkg::t_tok             w_tok    [ENTRIES+1];
    logic [ID_BITS-1:0]          w_new_id [ENTRIES+1];
    logic [ID_BITS-1:0]          w_res_id [ENTRIES+1];

    // register port
    assign pready   = 1'b1;
    assign w_reg_wr = psel && penable && pwrite && pready && (paddr[2] == stidl_pkg::REG_KEY_LIMIT);
    assign prdata   = (paddr[2] == stidl_pkg::REG_KEY_LIMIT) ? 32'(r_key_limit) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit <= stidl_pkg::KEY_LIMIT_RESET;
        end else if (w_reg_wr) begin
            r_key_limit <= pwdata[stidl_pkg::KEY_W-1:0];
        end
    end

    // entry checks that need no slot state
    always_comb begin
        case (i_in_data.mode)
            stidl_pkg::MODE_INSERT: begin
                w_pre_err = (i_in_data.key_in < stidl_pkg::MIN_INSERT_KEY) ||
                            (i_in_data.key_in > r_key_limit);
            end
            stidl_pkg::MODE_MODIFY: begin
                w_pre_err = (i_in_data.key_in > r_key_limit);
            end
            stidl_pkg::MODE_REMOVE,
            stidl_pkg::MODE_FREE,
            stidl_pkg::MODE_BYID: begin
                w_pre_err = 1'b0;
            end
            default: begin
                w_pre_err = 1'b1;
            end
        endcase
        n_tok0.mode     = i_in_data.mode;
        n_tok0.slot     = i_in_data.slot;
        n_tok0.key      = i_in_data.key_in;
        n_tok0.sid      = i_in_data.search_id;
        n_tok0.done     = w_pre_err;
        n_tok0.err      = w_pre_err;
        n_tok0.hit_slot = '0;
    end

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = w_vld[ENTRIES];
    // row holds while a finished word cannot leave
    assign w_adv      = !(w_last && r_out_vld && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld0 <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_accept) begin
                r_vld0 <= 1'b1;
            end else if (w_adv) begin
                r_vld0 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok0 <= n_tok0;
            r_new0 <= r_cnt + ID_BITS'(1);
        end
    end

    assign w_vld[0]    = r_vld0;
    assign w_tok[0]    = r_tok0;
    assign w_new_id[0] = r_new0;
    assign w_res_id[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        stidl_cell #(
            .IDX     (g),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_vld    (w_vld[g]),
            .i_tok    (w_tok[g]),
            .i_new_id (w_new_id[g]),
            .i_res_id (w_res_id[g]),
            .o_vld    (w_vld[g+1]),
            .o_tok    (w_tok[g+1]),
            .o_new_id (w_new_id[g+1]),
            .o_res_id (w_res_id[g+1])
        );
    end

    // result formatting at the end of the row; unresolved means error
    assign w_ok      = w_tok[ENTRIES].done && !w_tok[ENTRIES].err;
    assign w_res_ext = CMP_W'(w_res_id[ENTRIES]);

    always_comb begin
        n_out.status      = !w_ok;
        n_out.found_slot  = '0;
        n_out.assigned_id = '0;
        if (w_ok) begin
            if ((w_tok[ENTRIES].mode == stidl_pkg::MODE_FREE) ||
                (w_tok[ENTRIES].mode == stidl_pkg::MODE_BYID)) begin
                n_out.found_slot = w_tok[ENTRIES].hit_slot;
            end
            if (w_tok[ENTRIES].mode != stidl_pkg::MODE_FREE) begin
                n_out.assigned_id = w_res_ext[stidl_pkg::OUT_ID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (w_adv && w_last) begin
                r_out_vld <= 1'b1;
                if (w_ok && (w_tok[ENTRIES].mode == stidl_pkg::MODE_INSERT)) begin
                    r_cnt <= w_new_id[ENTRIES];
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench for slot_table_with_id_lookup: directed and random table commands,
// key limit writes over the apb port and id reuse on a churned slot
// depends on stidl_pkg and the slot_table_with_id_lookup rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 8;
    localparam int ID_BITS = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    stidl_pkg::t_in_word cmd_word = '0;
    logic out_ready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;

    logic o_in_ready;
    logic o_out_valid;
    stidl_pkg::t_out_word o_out_data;
    logic [31:0] prdata;
    logic pready;

    slot_table_with_id_lookup #(
        .ENTRIES(ENTRIES),
        .ID_BITS(ID_BITS)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(cmd_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(cmd_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // table shadow kept in step with every accepted word
    logic        slot_live [ENTRIES];
    logic [9:0]  slot_key [ENTRIES];
    logic [15:0] slot_id [ENTRIES];
    logic [15:0] id_ctr = '0;
    logic [9:0]  key_lim = stidl_pkg::KEY_LIMIT_RESET;

    stidl_pkg::t_out_word due_results [$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int words_checked = 0;
    int commands_sent = 0;
    int limit_writes = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i] = '0;
            slot_id[i] = '0;
        end
    end

    function automatic stidl_pkg::t_out_word table_outcome(stidl_pkg::t_in_word w);
        stidl_pkg::t_out_word r;
        int s;
        logic hit;
        r = '0;
        r.status = 1'b1;
        s = int'(w.slot);
        hit = 1'b0;
        case (w.mode)
            stidl_pkg::MODE_INSERT: begin
                if (s < ENTRIES && !slot_live[s] && w.key_in >= stidl_pkg::MIN_INSERT_KEY
                        && w.key_in <= key_lim) begin
                    id_ctr = id_ctr + 16'd1;
                    slot_key[s] = w.key_in;
                    slot_id[s] = id_ctr;
                    slot_live[s] = 1'b1;
                    r.status = 1'b0;
                    r.assigned_id = id_ctr;
                end
            end
            stidl_pkg::MODE_MODIFY: begin
                if (s < ENTRIES && slot_live[s] && w.key_in <= key_lim) begin
                    slot_key[s] = w.key_in;
                    r.status = 1'b0;
                    r.assigned_id = slot_id[s];
                end
            end
            stidl_pkg::MODE_REMOVE: begin
                if (s < ENTRIES && slot_live[s]) begin
                    slot_live[s] = 1'b0;
                    r.status = 1'b0;
                    r.assigned_id = slot_id[s];
                end
            end
            stidl_pkg::MODE_FREE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!hit && !slot_live[i]) begin
                        hit = 1'b1;
                        r.status = 1'b0;
                        r.found_slot = 3'(i);
                    end
                end
            end
            stidl_pkg::MODE_BYID: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!hit && slot_live[i] && slot_id[i] == w.search_id) begin
                        hit = 1'b1;
                        r.status = 1'b0;
                        r.found_slot = 3'(i);
                        r.assigned_id = slot_id[i];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin : result_port
        stidl_pkg::t_out_word want;
        if (rst_n && o_out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result word with nothing due", 32'(o_out_data), 32'd0);
            end else begin
                want = due_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                if (o_out_data.found_slot !== want.found_slot)
                    report_mismatch("found_slot", 32'(o_out_data.found_slot),
                                    32'(want.found_slot));
                if (o_out_data.assigned_id !== want.assigned_id)
                    report_mismatch("assigned_id", 32'(o_out_data.assigned_id),
                                    32'(want.assigned_id));
                words_checked++;
            end
        end
    end

    // valid stays up after acceptance; the next call drops it or reloads it
    task automatic send_word(stidl_pkg::t_in_word w);
        int gap;
        gap = 0;
        while (gap < 32 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word <= w;
        forever begin
            @(posedge clk);
            if (o_in_ready)
                break;
        end
        due_results.push_back(table_outcome(w));
        commands_sent++;
    endtask

    task automatic issue(logic [2:0] mode, logic [2:0] slot, logic [9:0] key,
                         logic [15:0] sid);
        stidl_pkg::t_in_word w;
        w.mode = mode;
        w.slot = slot;
        w.key_in = key;
        w.search_id = sid;
        send_word(w);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);
    endtask

    task automatic write_key_limit(logic [9:0] value);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(stidl_pkg::REG_KEY_LIMIT));
        // upper bits are junk, only the low ten are kept
        pwdata <= ($urandom() & ~32'h3FF) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        key_lim = value;
        limit_writes++;
    endtask

    task automatic set_idle(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
    endtask

    function automatic logic [2:0] pick_slot(logic live);
        int start;
        int idx;
        start = $urandom_range(ENTRIES - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            idx = (start + i) % ENTRIES;
            if (slot_live[idx] == live)
                return 3'(idx);
        end
        return 3'(start);
    endfunction

    function automatic logic [9:0] legal_key(logic for_insert);
        int lo;
        lo = for_insert ? int'(stidl_pkg::MIN_INSERT_KEY) : 0;
        if (int'(key_lim) < lo)
            return 10'($urandom());
        case ($urandom_range(7))
            0: return 10'(lo);
            1: return key_lim;
            default: return 10'($urandom_range(int'(key_lim), lo));
        endcase
    endfunction

    function automatic stidl_pkg::t_in_word random_command();
        stidl_pkg::t_in_word w;
        int roll;
        w = stidl_pkg::t_in_word'($urandom());
        roll = $urandom_range(99);
        if (roll < 30) begin
            w.mode = stidl_pkg::MODE_INSERT;
            w.slot = pick_slot(1'b0);
            w.key_in = legal_key(1'b1);
        end else if (roll < 50) begin
            w.mode = stidl_pkg::MODE_MODIFY;
            w.slot = pick_slot(1'b1);
            w.key_in = legal_key(1'b0);
        end else if (roll < 68) begin
            w.mode = stidl_pkg::MODE_REMOVE;
            w.slot = pick_slot(1'b1);
        end else if (roll < 76) begin
            w.mode = stidl_pkg::MODE_FREE;
        end else if (roll < 86) begin
            w.mode = stidl_pkg::MODE_BYID;
            w.search_id = slot_id[pick_slot(1'b1)];
        end else if ($urandom_range(1) == 0) begin
            // noise with keys on the edges of the accepted range
            case ($urandom_range(3))
                0: w.key_in = '0;
                1: w.key_in = key_lim;
                2: w.key_in = key_lim + 10'd1;
                default: w.key_in = '1;
            endcase
        end
        return w;
    endfunction

    task automatic test_directed_table();
        set_idle(11, 11);
        issue(stidl_pkg::MODE_FREE, 3'd0, 10'd0, 16'd0);
        issue(stidl_pkg::MODE_BYID, 3'd0, 10'd0, 16'd0);
        issue(stidl_pkg::MODE_INSERT, 3'd0, 10'd0, 16'hFFFF);
        issue(stidl_pkg::MODE_INSERT, 3'd0, 10'd1001, 16'd0);
        issue(stidl_pkg::MODE_INSERT, 3'd0, stidl_pkg::MIN_INSERT_KEY, 16'd0);
        issue(stidl_pkg::MODE_INSERT, 3'd0, 10'd5, 16'd0);
        issue(stidl_pkg::MODE_INSERT, 3'd7, stidl_pkg::KEY_LIMIT_RESET, 16'd0);
        issue(stidl_pkg::MODE_MODIFY, 3'd0, 10'd0, 16'd0);
        issue(stidl_pkg::MODE_MODIFY, 3'd7, 10'd1001, 16'd0);
        issue(stidl_pkg::MODE_MODIFY, 3'd3, 10'd9, 16'd0);
        issue(stidl_pkg::MODE_REMOVE, 3'd3, 10'd0, 16'd0);
        issue(stidl_pkg::MODE_FREE, 3'd7, 10'h3FF, 16'hFFFF);
        issue(stidl_pkg::MODE_BYID, 3'd0, 10'd0, 16'd2);
        issue(stidl_pkg::MODE_BYID, 3'd0, 10'd0, 16'hFFFF);
        for (int m = int'(stidl_pkg::MODE_BYID) + 1; m < 2 ** stidl_pkg::MODE_W; m++)
            issue(3'(m), 3'($urandom()), 10'($urandom()), 16'($urandom()));
        issue(stidl_pkg::MODE_REMOVE, 3'd7, 10'd0, 16'd0);
        for (int s = 1; s < ENTRIES; s++)
            issue(stidl_pkg::MODE_INSERT, 3'(s), legal_key(1'b1), 16'd0);
        // table is full now
        issue(stidl_pkg::MODE_FREE, 3'd0, 10'd0, 16'd0);
    endtask

    task automatic test_key_limit_edges();
        issue(stidl_pkg::MODE_REMOVE, pick_slot(1'b1), 10'd0, 16'd0);
        write_key_limit(10'd0);
        issue(stidl_pkg::MODE_INSERT, pick_slot(1'b0), stidl_pkg::MIN_INSERT_KEY, 16'd0);
        issue(stidl_pkg::MODE_MODIFY, pick_slot(1'b1), 10'd0, 16'd0);
        issue(stidl_pkg::MODE_MODIFY, pick_slot(1'b1), 10'd1, 16'd0);
        write_key_limit(10'h3FF);
        issue(stidl_pkg::MODE_INSERT, pick_slot(1'b0), 10'h3FF, 16'd0);
        issue(stidl_pkg::MODE_MODIFY, pick_slot(1'b1), 10'h3FF, 16'd0);
        write_key_limit(stidl_pkg::KEY_LIMIT_RESET);
        issue(stidl_pkg::MODE_MODIFY, pick_slot(1'b1), 10'h3FF, 16'd0);
    endtask

    task automatic test_random_traffic(int sender_pct, int receiver_pct,
                                       logic [9:0] limit, int count);
        write_key_limit(limit);
        set_idle(sender_pct, receiver_pct);
        for (int n = 0; n < count; n++)
            send_word(random_command());
    endtask

    task automatic test_id_reuse();
        logic [15:0] next_id;
        write_key_limit(stidl_pkg::KEY_LIMIT_RESET);
        set_idle(11, 11);
        if (slot_live[0])
            issue(stidl_pkg::MODE_REMOVE, 3'd0, 10'd0, 16'd0);
        // a removed slot must stop answering to its old id
        for (int k = 0; k < 3; k++) begin
            next_id = id_ctr + 16'd1;
            issue(stidl_pkg::MODE_INSERT, 3'd0, legal_key(1'b1), 16'd0);
            issue(stidl_pkg::MODE_BYID, 3'd0, 10'd0, next_id);
            issue(stidl_pkg::MODE_MODIFY, 3'd0, legal_key(1'b0), 16'd0);
            issue(stidl_pkg::MODE_REMOVE, 3'd0, 10'd0, 16'd0);
            issue(stidl_pkg::MODE_BYID, 3'd0, 10'd0, next_id);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_table();
        test_key_limit_edges();
        test_random_traffic(0, 0, stidl_pkg::KEY_LIMIT_RESET, 450);
        test_random_traffic(69, 0, 10'($urandom_range(1023)), 450);
        test_random_traffic(0, 69, 10'($urandom_range(15, 1)), 450);
        test_random_traffic(11, 11, 10'h3FF, 450);
        test_id_reuse();
        settle();
        $display("covered %0d commands and %0d result words, %0d key limit writes",
                 commands_sent, words_checked, limit_writes);
        $display("last id handed out %0h, %0d mismatches", id_ctr, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d words still due", due_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
